FILE: rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

    // Result field widths are fixed by the output format.
    localparam int LINE_W = 20;
    localparam int COL_W  = 16;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;
    localparam logic [COL_W-1:0]  COL_MAX  = '1;

    // Queue between the scanner and the output side.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Token kinds.
    localparam logic [4:0] KIND_PENDING = 5'd0;
    localparam logic [4:0] KIND_STRING  = 5'd1;
    localparam logic [4:0] KIND_INTEGER = 5'd2;
    localparam logic [4:0] KIND_DECIMAL = 5'd3;
    localparam logic [4:0] KIND_BOOLEAN = 5'd4;
    localparam logic [4:0] KIND_IDENT   = 5'd5;
    localparam logic [4:0] KIND_SEMI    = 5'd6;
    localparam logic [4:0] KIND_LPAREN  = 5'd7;
    localparam logic [4:0] KIND_RPAREN  = 5'd8;
    localparam logic [4:0] KIND_LBRACK  = 5'd9;
    localparam logic [4:0] KIND_RBRACK  = 5'd10;
    localparam logic [4:0] KIND_LBRACE  = 5'd11;
    localparam logic [4:0] KIND_RBRACE  = 5'd12;
    localparam logic [4:0] KIND_PLUS    = 5'd13;
    localparam logic [4:0] KIND_MINUS   = 5'd14;
    localparam logic [4:0] KIND_STAR    = 5'd15;
    localparam logic [4:0] KIND_SLASH   = 5'd16;
    localparam logic [4:0] KIND_PERCENT = 5'd17;
    localparam logic [4:0] KIND_EQUAL   = 5'd18;

    // Error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_SECOND_DOT = 2'd2;

    // Characters.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;
    localparam logic [7:0] CH_LOW_S  = 8'h73;

    // Keyword progress: 1..4 inside "true", 5..9 inside "false".
    localparam logic [3:0] KW_NONE       = 4'd0;
    localparam logic [3:0] KW_TRUE_T     = 4'd1;
    localparam logic [3:0] KW_TRUE_R     = 4'd2;
    localparam logic [3:0] KW_TRUE_U     = 4'd3;
    localparam logic [3:0] KW_TRUE_DONE  = 4'd4;
    localparam logic [3:0] KW_FALSE_F    = 4'd5;
    localparam logic [3:0] KW_FALSE_A    = 4'd6;
    localparam logic [3:0] KW_FALSE_L    = 4'd7;
    localparam logic [3:0] KW_FALSE_S    = 4'd8;
    localparam logic [3:0] KW_FALSE_DONE = 4'd9;

    typedef struct packed {
        logic [4:0]        kind;
        logic [7:0]        value;
        logic              has_byte;
        logic              tok_end;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [1:0]        err;
    } t_item;

    // Up to two result words per accepted byte.
    typedef struct packed {
        logic [1:0] count;
        t_item      first;
        t_item      second;
    } t_push;

endpackage

`default_nettype wire

FILE: rtl/stt_front.sv
`default_nettype none

module stt_front
    import stt_pkg::*;
#(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_end_of_input,
    input  wire logic       i_room,
    output t_push           o_push
);

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_DQ,
        MODE_SQ,
        MODE_DQ_ESC,
        MODE_SQ_ESC,
        MODE_NUM,
        MODE_WORD,
        MODE_COMMENT
    } t_mode;

    t_mode                  r_mode, n_mode;
    logic                   r_dec, n_dec;
    logic [3:0]             r_kw, n_kw;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [LINE_BITS-1:0]   r_sline, n_sline;
    logic [COLUMN_BITS-1:0] r_scol, n_scol;

    logic       accept;
    logic [1:0] cnt;
    t_item      it0, it1, st;
    logic       st_emit, restart;
    logic [LINE_W-1:0] old_line_o, new_line_o;
    logic [COL_W-1:0]  old_col_o, new_col_o;
    logic [7:0] b;

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic [LINE_W-1:0] f_sat_line(input logic [LINE_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > 33'(LINE_MAX)) return LINE_MAX;
        return w[LINE_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] f_sat_col(input logic [COLUMN_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > 33'(COL_MAX)) return COL_MAX;
        return w[COL_W-1:0];
    endfunction

    function automatic logic [3:0] f_kw_next(input logic [3:0] k, input logic [7:0] c);
        logic [3:0] r;
        r = KW_NONE;
        case (k)
            KW_TRUE_T:  if (c == CH_LOW_R) r = KW_TRUE_R;
            KW_TRUE_R:  if (c == CH_LOW_U) r = KW_TRUE_U;
            KW_TRUE_U:  if (c == CH_LOW_E) r = KW_TRUE_DONE;
            KW_FALSE_F: if (c == CH_LOW_A) r = KW_FALSE_A;
            KW_FALSE_A: if (c == CH_LOW_L) r = KW_FALSE_L;
            KW_FALSE_L: if (c == CH_LOW_S) r = KW_FALSE_S;
            KW_FALSE_S: if (c == CH_LOW_E) r = KW_FALSE_DONE;
            default:    r = KW_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] f_sym_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h3B:   k = KIND_SEMI;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h5B:   k = KIND_LBRACK;
            8'h5D:   k = KIND_RBRACK;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h25:   k = KIND_PERCENT;
            8'h3D:   k = KIND_EQUAL;
            default: k = KIND_PENDING;
        endcase
        return k;
    endfunction

    function automatic t_item f_mk(input logic [4:0] kind, input logic [7:0] val,
                                   input logic has, input logic fin, input logic [1:0] err,
                                   input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] cl);
        t_item x;
        x.kind     = kind;
        x.value    = val;
        x.has_byte = has;
        x.tok_end  = fin;
        x.line     = ln;
        x.column   = cl;
        x.err      = err;
        return x;
    endfunction

    assign accept = i_valid && i_room;
    assign b      = i_char_byte;

    always_comb begin
        n_mode  = r_mode;
        n_dec   = r_dec;
        n_kw    = r_kw;
        n_line  = r_line;
        n_col   = r_col;
        n_sline = r_sline;
        n_scol  = r_scol;
        cnt     = 2'd0;
        it0     = '0;
        it1     = '0;
        st      = '0;
        st_emit = 1'b0;
        restart = 1'b0;

        old_line_o = f_sat_line(r_sline);
        old_col_o  = f_sat_col(r_scol);

        if (!i_end_of_input) begin
            if (b == CH_NL) begin
                if (r_line != '1) n_line = r_line + LINE_BITS'(1);
                n_col = '0;
            end else if (r_col != '1) begin
                n_col = r_col + COLUMN_BITS'(1);
            end
        end
        new_line_o = f_sat_line(n_line);
        new_col_o  = f_sat_col(n_col);

        if (i_end_of_input) begin
            case (r_mode)
                MODE_DQ, MODE_SQ, MODE_DQ_ESC, MODE_SQ_ESC: begin
                    it0 = f_mk(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE,
                               old_line_o, old_col_o);
                    cnt = 2'd1;
                end
                MODE_NUM: begin
                    it0 = f_mk(r_dec ? KIND_DECIMAL : KIND_INTEGER, 8'd0, 1'b0, 1'b1,
                               ERR_NONE, old_line_o, old_col_o);
                    cnt = 2'd1;
                end
                MODE_WORD: begin
                    it0 = f_mk((r_kw == KW_TRUE_DONE || r_kw == KW_FALSE_DONE) ?
                               KIND_BOOLEAN : KIND_IDENT, 8'd0, 1'b0, 1'b1, ERR_NONE,
                               old_line_o, old_col_o);
                    cnt = 2'd1;
                end
                default: cnt = 2'd0;
            endcase
            n_mode = MODE_IDLE;
            n_dec  = 1'b0;
            n_kw   = KW_NONE;
        end else begin
            case (r_mode)
                MODE_DQ, MODE_SQ: begin
                    if (b == ((r_mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
                        n_mode = MODE_IDLE;
                        it0 = f_mk(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE,
                                   old_line_o, old_col_o);
                        cnt = 2'd1;
                    end else if (b == CH_BSLASH) begin
                        n_mode = (r_mode == MODE_DQ) ? MODE_DQ_ESC : MODE_SQ_ESC;
                    end else begin
                        it0 = f_mk(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE,
                                   old_line_o, old_col_o);
                        cnt = 2'd1;
                    end
                end
                MODE_DQ_ESC, MODE_SQ_ESC: begin
                    n_mode = (r_mode == MODE_DQ_ESC) ? MODE_DQ : MODE_SQ;
                    cnt    = 2'd1;
                    if (b == CH_LOW_N) begin
                        it0 = f_mk(KIND_PENDING, CH_NL, 1'b1, 1'b0, ERR_NONE,
                                   old_line_o, old_col_o);
                    end else if (b == CH_LOW_T) begin
                        it0 = f_mk(KIND_PENDING, CH_TAB, 1'b1, 1'b0, ERR_NONE,
                                   old_line_o, old_col_o);
                    end else if (b == CH_BSLASH || b == CH_SQUOTE || b == CH_DQUOTE) begin
                        it0 = f_mk(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE,
                                   old_line_o, old_col_o);
                    end else begin
                        // Unknown escape: pass both bytes through, flagged.
                        it0 = f_mk(KIND_PENDING, CH_BSLASH, 1'b1, 1'b0, ERR_BAD_ESCAPE,
                                   old_line_o, old_col_o);
                        it1 = f_mk(KIND_PENDING, b, 1'b1, 1'b0, ERR_BAD_ESCAPE,
                                   old_line_o, old_col_o);
                        cnt = 2'd2;
                    end
                end
                MODE_COMMENT: begin
                    if (b == CH_NL) n_mode = MODE_IDLE;
                end
                MODE_NUM: begin
                    if (f_is_digit(b) || b == CH_DOT) begin
                        it0 = f_mk(KIND_PENDING, b, 1'b1, 1'b0,
                                   (b == CH_DOT && r_dec) ? ERR_SECOND_DOT : ERR_NONE,
                                   old_line_o, old_col_o);
                        cnt = 2'd1;
                        if (b == CH_DOT) n_dec = 1'b1;
                    end else begin
                        it0 = f_mk(r_dec ? KIND_DECIMAL : KIND_INTEGER, 8'd0, 1'b0, 1'b1,
                                   ERR_NONE, old_line_o, old_col_o);
                        cnt     = 2'd1;
                        n_mode  = MODE_IDLE;
                        n_dec   = 1'b0;
                        restart = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (f_is_alpha(b) || f_is_digit(b) || b == CH_USCORE) begin
                        n_kw = f_kw_next(r_kw, b);
                        it0  = f_mk(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE,
                                    old_line_o, old_col_o);
                        cnt  = 2'd1;
                    end else begin
                        it0 = f_mk((r_kw == KW_TRUE_DONE || r_kw == KW_FALSE_DONE) ?
                                   KIND_BOOLEAN : KIND_IDENT, 8'd0, 1'b0, 1'b1, ERR_NONE,
                                   old_line_o, old_col_o);
                        cnt     = 2'd1;
                        n_mode  = MODE_IDLE;
                        n_kw    = KW_NONE;
                        restart = 1'b1;
                    end
                end
                default: begin
                    n_mode  = MODE_IDLE;
                    restart = 1'b1;
                end
            endcase

            // A byte that closes a number or word also opens the next token.
            if (restart) begin
                n_sline = n_line;
                n_scol  = n_col;
                if (b == CH_DQUOTE) begin
                    n_mode = MODE_DQ;
                end else if (b == CH_SQUOTE) begin
                    n_mode = MODE_SQ;
                end else if (f_is_digit(b) || b == CH_DOT) begin
                    n_mode  = MODE_NUM;
                    n_dec   = (b == CH_DOT);
                    st      = f_mk(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE,
                                   new_line_o, new_col_o);
                    st_emit = 1'b1;
                end else if (f_is_alpha(b) || b == CH_USCORE) begin
                    n_mode  = MODE_WORD;
                    n_kw    = (b == CH_LOW_T) ? KW_TRUE_T :
                              (b == CH_LOW_F) ? KW_FALSE_F : KW_NONE;
                    st      = f_mk(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE,
                                   new_line_o, new_col_o);
                    st_emit = 1'b1;
                end else if (b == CH_HASH) begin
                    n_mode = MODE_COMMENT;
                end else if (f_sym_kind(b) != KIND_PENDING) begin
                    st      = f_mk(f_sym_kind(b), b, 1'b1, 1'b1, ERR_NONE,
                                   new_line_o, new_col_o);
                    st_emit = 1'b1;
                end
                if (st_emit) begin
                    if (cnt == 2'd0) it0 = st;
                    else             it1 = st;
                    cnt = cnt + 2'd1;
                end
            end
        end
    end

    always_comb begin
        o_push.count  = accept ? cnt : 2'd0;
        o_push.first  = it0;
        o_push.second = it1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_dec   <= 1'b0;
            r_kw    <= KW_NONE;
            r_line  <= LINE_BITS'(1);
            r_col   <= '0;
            r_sline <= LINE_BITS'(1);
            r_scol  <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_dec   <= n_dec;
            r_kw    <= n_kw;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
        end
    end

    a_eoi_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_input) |=> (r_mode == MODE_IDLE && !r_dec && r_kw == KW_NONE))
        else $error("scanner not idle after end of text");

    a_esc_from_dq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_DQ_ESC) |-> ($past(r_mode) == MODE_DQ || $past(r_mode) == MODE_DQ_ESC))
        else $error("escape entered outside a double-quoted string");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line != '0) && (r_sline != '0))
        else $error("line counter reached zero");

endmodule

`default_nettype wire

FILE: rtl/stt_queue.sv
`default_nettype none

module stt_queue
    import stt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_item      o_item
);

    t_item              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               pop;

    // Room is checked for two words so a byte never has to be split.
    assign o_room  = (QCNT_W'(QUEUE_DEPTH) - r_count) >= QCNT_W'(2);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_count = r_count + QCNT_W'(i_push.count) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wp] <= i_push.first;
        if (i_push.count == 2'd2) r_mem[r_wp + QPTR_W'(1)] <= i_push.second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + QPTR_W'(i_push.count);
            r_rp    <= r_rp + QPTR_W'(pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("push without room");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_push.count == 2'd0) |=> (r_count == $past(r_count) - QCNT_W'(1)))
        else $error("queue level wrong after a pop");

endmodule

`default_nettype wire

FILE: rtl/source_text_tokenizer_top.sv
// Channel   Direction  Handshake               Word
// input     in         i_in_valid/o_in_stall   i_char_byte, i_end_of_input
// output    out        o_out_valid/i_out_stall o_token_kind .. o_error_code
//
// One source byte is taken per cycle while o_in_stall is low; it yields zero, one or two token words.
// The output side drains one word a cycle while i_out_stall is low, and a four-entry
// queue absorbs bursts.
// A word appears on the output in the cycle after its byte is taken at the
// earliest, later when older words still wait in the queue.
// Synchronous active-low reset clears the scanner and empties the queue.
// o_in_stall rises when the queue has room for fewer than two words.
`default_nettype none

module source_text_tokenizer_top
    import stt_pkg::*;
#(
    parameter int LINE_BITS   = 20,
    parameter int COLUMN_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [7:0]        i_char_byte,
    input  wire logic              i_end_of_input,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [4:0]             o_token_kind,
    output logic [7:0]             o_value_byte,
    output logic                   o_has_byte,
    output logic                   o_token_end,
    output logic [LINE_W-1:0]      o_token_line,
    output logic [COL_W-1:0]       o_token_column,
    output logic [1:0]             o_error_code
);

    t_push push;
    t_item item;
    logic  room;

    stt_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .i_room         (room),
        .o_push         (push)
    );

    stt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (item)
    );

    assign o_in_stall     = !room;
    assign o_token_kind   = item.kind;
    assign o_value_byte   = item.value;
    assign o_has_byte     = item.has_byte;
    assign o_token_end    = item.tok_end;
    assign o_token_line   = item.line;
    assign o_token_column = item.column;
    assign o_error_code   = item.err;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import stt_pkg::*;

    localparam int PERIOD       = 20;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_PRINTS   = 40;
    localparam int LONG_LINE    = 60;

    localparam logic [7:0] SYM_BYTES [13] = '{";", "(", ")", "[", "]", "{", "}",
                                              "+", "-", "*", "/", "%", "="};
    localparam logic [7:0] ESCAPE_BYTES [5] = '{CH_LOW_N, CH_LOW_T, CH_BSLASH,
                                                 CH_SQUOTE, CH_DQUOTE};

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_DQ, SCAN_SQ, SCAN_DQ_ESC, SCAN_SQ_ESC,
        SCAN_NUM, SCAN_WORD, SCAN_COMMENT
    } t_scan;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [7:0]        i_char_byte = 8'h00;
    logic              i_end_of_input = 1'b0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [4:0]        o_token_kind;
    logic [7:0]        o_value_byte;
    logic              o_has_byte;
    logic              o_token_end;
    logic [LINE_W-1:0] o_token_line;
    logic [COL_W-1:0]  o_token_column;
    logic [1:0]        o_error_code;

    // Scanner state as the block should hold it.
    t_scan             scan_state = SCAN_IDLE;
    logic              in_decimal = 1'b0;
    logic [3:0]        kw_state = KW_NONE;
    logic [LINE_W-1:0] cur_line = 1;
    logic [COL_W-1:0]  cur_col = '0;
    logic [LINE_W-1:0] tok_line = 1;
    logic [COL_W-1:0]  tok_col = '0;

    t_item expected_tokens [$];
    int    error_count = 0;
    int    words_checked = 0;
    int    sent_count = 0;
    int    cycle_count = 0;
    int    gap_pct = 0;
    int    stall_pct = 0;
    int    hold_request = 0;
    int    hold_left = 0;

    string word_samples [10] = '{"true", "false", "tru", "fals", "trues", "falsey",
                                 "t", "f", "x_1", "_Ab9"};

    source_text_tokenizer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_byte    (i_char_byte),
        .i_end_of_input (i_end_of_input),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_value_byte   (o_value_byte),
        .o_has_byte     (o_has_byte),
        .o_token_end    (o_token_end),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column),
        .o_error_code   (o_error_code)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic [3:0] next_keyword(logic [3:0] k, logic [7:0] b);
        case (k)
            KW_TRUE_T:  return (b == CH_LOW_R) ? KW_TRUE_R : KW_NONE;
            KW_TRUE_R:  return (b == CH_LOW_U) ? KW_TRUE_U : KW_NONE;
            KW_TRUE_U:  return (b == CH_LOW_E) ? KW_TRUE_DONE : KW_NONE;
            KW_FALSE_F: return (b == CH_LOW_A) ? KW_FALSE_A : KW_NONE;
            KW_FALSE_A: return (b == CH_LOW_L) ? KW_FALSE_L : KW_NONE;
            KW_FALSE_L: return (b == CH_LOW_S) ? KW_FALSE_S : KW_NONE;
            KW_FALSE_S: return (b == CH_LOW_E) ? KW_FALSE_DONE : KW_NONE;
            default:    return KW_NONE;
        endcase
    endfunction

    function automatic logic [4:0] word_kind();
        return (kw_state == KW_TRUE_DONE || kw_state == KW_FALSE_DONE) ?
               KIND_BOOLEAN : KIND_IDENT;
    endfunction

    task automatic push_token(logic [4:0] kind, logic [7:0] val, logic has,
                              logic closes, logic [1:0] err);
        t_item w;
        w.kind     = kind;
        w.value    = val;
        w.has_byte = has;
        w.tok_end  = closes;
        w.line     = tok_line;
        w.column   = tok_col;
        w.err      = err;
        expected_tokens.insert(expected_tokens.size(), w);
    endtask

    task automatic begin_token(logic [7:0] b);
        tok_line = cur_line;
        tok_col  = cur_col;
        if (b == CH_DQUOTE) begin
            scan_state = SCAN_DQ;
        end else if (b == CH_SQUOTE) begin
            scan_state = SCAN_SQ;
        end else if (is_digit(b) || b == CH_DOT) begin
            scan_state = SCAN_NUM;
            in_decimal = (b == CH_DOT);
            push_token(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE);
        end else if (is_alpha(b) || b == CH_USCORE) begin
            scan_state = SCAN_WORD;
            kw_state = (b == CH_LOW_T) ? KW_TRUE_T : (b == CH_LOW_F) ? KW_FALSE_F : KW_NONE;
            push_token(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE);
        end else if (b == CH_HASH) begin
            scan_state = SCAN_COMMENT;
        end else begin
            for (int i = 0; i < 13; i++)
                if (b == SYM_BYTES[i])
                    push_token(KIND_SEMI + 5'(i), b, 1'b1, 1'b1, ERR_NONE);
        end
    endtask

    // Works out the words that one accepted input word must produce.
    task automatic predict_tokens(logic [7:0] b, logic eoi);
        logic [7:0] closer;
        if (eoi) begin
            case (scan_state)
                SCAN_DQ, SCAN_SQ, SCAN_DQ_ESC, SCAN_SQ_ESC:
                    push_token(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
                SCAN_NUM:
                    push_token(in_decimal ? KIND_DECIMAL : KIND_INTEGER, 8'h00, 1'b0, 1'b1,
                               ERR_NONE);
                SCAN_WORD:
                    push_token(word_kind(), 8'h00, 1'b0, 1'b1, ERR_NONE);
                default: ;
            endcase
            scan_state = SCAN_IDLE;
            in_decimal = 1'b0;
            kw_state   = KW_NONE;
            return;
        end

        if (b == CH_NL) begin
            if (cur_line != LINE_MAX) cur_line++;
            cur_col = '0;
        end else if (cur_col != COL_MAX) begin
            cur_col++;
        end

        case (scan_state)
            SCAN_DQ, SCAN_SQ: begin
                closer = (scan_state == SCAN_DQ) ? CH_DQUOTE : CH_SQUOTE;
                if (b == closer) begin
                    scan_state = SCAN_IDLE;
                    push_token(KIND_STRING, 8'h00, 1'b0, 1'b1, ERR_NONE);
                end else if (b == CH_BSLASH) begin
                    if (scan_state == SCAN_DQ) scan_state = SCAN_DQ_ESC;
                    else scan_state = SCAN_SQ_ESC;
                end else begin
                    push_token(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE);
                end
                return;
            end
            SCAN_DQ_ESC, SCAN_SQ_ESC: begin
                if (scan_state == SCAN_DQ_ESC) scan_state = SCAN_DQ;
                else scan_state = SCAN_SQ;
                if (b == CH_LOW_N) begin
                    push_token(KIND_PENDING, CH_NL, 1'b1, 1'b0, ERR_NONE);
                end else if (b == CH_LOW_T) begin
                    push_token(KIND_PENDING, CH_TAB, 1'b1, 1'b0, ERR_NONE);
                end else if (b == CH_BSLASH || b == CH_SQUOTE || b == CH_DQUOTE) begin
                    push_token(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE);
                end else begin
                    // An unknown escape passes both bytes through, flagged.
                    push_token(KIND_PENDING, CH_BSLASH, 1'b1, 1'b0, ERR_BAD_ESCAPE);
                    push_token(KIND_PENDING, b, 1'b1, 1'b0, ERR_BAD_ESCAPE);
                end
                return;
            end
            SCAN_COMMENT: begin
                if (b == CH_NL) scan_state = SCAN_IDLE;
                return;
            end
            SCAN_NUM: begin
                if (is_digit(b) || b == CH_DOT) begin
                    push_token(KIND_PENDING, b, 1'b1, 1'b0,
                               (b == CH_DOT && in_decimal) ? ERR_SECOND_DOT : ERR_NONE);
                    if (b == CH_DOT) in_decimal = 1'b1;
                    return;
                end
                push_token(in_decimal ? KIND_DECIMAL : KIND_INTEGER, 8'h00, 1'b0, 1'b1,
                           ERR_NONE);
                scan_state = SCAN_IDLE;
                in_decimal = 1'b0;
            end
            SCAN_WORD: begin
                if (is_alpha(b) || is_digit(b) || b == CH_USCORE) begin
                    kw_state = next_keyword(kw_state, b);
                    push_token(KIND_PENDING, b, 1'b1, 1'b0, ERR_NONE);
                    return;
                end
                push_token(word_kind(), 8'h00, 1'b0, 1'b1, ERR_NONE);
                scan_state = SCAN_IDLE;
                kw_state   = KW_NONE;
            end
            default: ;
        endcase
        // The byte that closed a number or word is scanned again from idle.
        begin_token(b);
    endtask

    task automatic put_byte(logic [7:0] b, logic eoi);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_char_byte    <= b;
        i_end_of_input <= eoi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_tokens(b, eoi);
        sent_count++;
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
    endtask

    task automatic put_end();
        put_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (error_count < MAX_PRINTS)
            $display("tb: word %0d %s: expected %0h, got %0h", words_checked, what, want, got);
        error_count++;
    endtask

    task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) report_mismatch(what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("arrived with nothing expected", 32'h0, o_token_kind);
            end else begin
                want = expected_tokens.pop_front();
                compare_field("kind", want.kind, o_token_kind);
                compare_field("value", want.value, o_value_byte);
                compare_field("has_byte", want.has_byte, o_has_byte);
                compare_field("token_end", want.tok_end, o_token_end);
                compare_field("line", want.line, o_token_line);
                compare_field("column", want.column, o_token_column);
                compare_field("error", want.err, o_error_code);
            end
            words_checked++;
        end
    end

    // Receiver: random stalls, or one long hold-off when a test asks for it.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic test_symbols();
        put_text(";()[]{}+-*/%= ");
    endtask

    task automatic test_strings();
        put_text("\"a\\n\\t\\q'\"");
        put_text("'\\\\\\'\\\"'");
    endtask

    task automatic test_numbers();
        put_text("0 9.5 .7 1.2.3;42x ");
    endtask

    task automatic test_words();
        put_text("true false trues fals _Z9 true");
        put_end();
    endtask

    task automatic test_comments();
        put_text("#c(\"\n");
    endtask

    task automatic test_end_of_input();
        put_text("\"ab\\");
        put_end();
        put_text("3.1");
        put_end();
        put_end();
        put_text("#z");
        put_end();
    endtask

    task automatic test_odd_bytes();
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(CH_TAB, 1'b0);
        put_text("@$\n");
    endtask

    // Moves the column counter far out along one line before a few tokens.
    task automatic test_long_line();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (LONG_LINE) put_byte(" ", 1'b0);
        put_text("ab;7\n");
    endtask

    // The receiver holds off while symbols keep coming, so the queue fills.
    task automatic test_backpressure();
        gap_pct      = 0;
        stall_pct    = 0;
        hold_request = LONG_HOLD;
        repeat (40) put_byte(SYM_BYTES[$urandom_range(12)], 1'b0);
        put_text("abc 12 ");
    endtask

    task automatic random_token();
        logic [7:0] quote;
        logic [7:0] c;
        case ($urandom_range(11))
            0, 1: begin
                quote = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                put_byte(quote, 1'b0);
                repeat ($urandom_range(6)) begin
                    case ($urandom_range(7))
                        0: begin
                            put_byte(CH_BSLASH, 1'b0);
                            put_byte(ESCAPE_BYTES[$urandom_range(4)], 1'b0);
                        end
                        1: begin
                            put_byte(CH_BSLASH, 1'b0);
                            put_byte(8'($urandom_range(255)), 1'b0);
                        end
                        default: begin
                            c = 8'($urandom_range("~", " "));
                            if (c == quote || c == CH_BSLASH) c = CH_LOW_A;
                            put_byte(c, 1'b0);
                        end
                    endcase
                end
                // Now and then the string is left open.
                if ($urandom_range(11) != 0) put_byte(quote, 1'b0);
            end
            2, 3: begin
                if ($urandom_range(4) == 0) put_byte(CH_DOT, 1'b0);
                repeat ($urandom_range(4, 1)) put_byte(8'($urandom_range("9", "0")), 1'b0);
                if ($urandom_range(2) == 0) begin
                    put_byte(CH_DOT, 1'b0);
                    repeat ($urandom_range(3)) put_byte(8'($urandom_range("9", "0")), 1'b0);
                end
                if ($urandom_range(7) == 0) begin
                    put_byte(CH_DOT, 1'b0);
                    put_byte(8'($urandom_range("9", "0")), 1'b0);
                end
            end
            4, 5: begin
                if ($urandom_range(1)) begin
                    put_text(word_samples[$urandom_range(9)]);
                end else begin
                    case ($urandom_range(2))
                        0: put_byte(8'($urandom_range("z", "a")), 1'b0);
                        1: put_byte(8'($urandom_range("Z", "A")), 1'b0);
                        default: put_byte(CH_USCORE, 1'b0);
                    endcase
                    repeat ($urandom_range(4)) begin
                        case ($urandom_range(3))
                            0: put_byte(8'($urandom_range("9", "0")), 1'b0);
                            1: put_byte(8'($urandom_range("Z", "A")), 1'b0);
                            2: put_byte(CH_USCORE, 1'b0);
                            default: put_byte(8'($urandom_range("z", "a")), 1'b0);
                        endcase
                    end
                end
            end
            6, 7: put_byte(SYM_BYTES[$urandom_range(12)], 1'b0);
            8: begin
                put_byte(CH_HASH, 1'b0);
                repeat ($urandom_range(5)) begin
                    c = 8'($urandom_range(255));
                    if (c == CH_NL) c = CH_LOW_A;
                    put_byte(c, 1'b0);
                end
                put_byte(CH_NL, 1'b0);
            end
            9: put_byte(8'($urandom_range(255)), 1'b0);
            10: put_end();
            default: put_byte($urandom_range(1) ? CH_TAB : CH_NL, 1'b0);
        endcase
        // Often no separator, so one token's last byte meets the next one's first.
        case ($urandom_range(3))
            0: put_byte(" ", 1'b0);
            1: put_byte(CH_NL, 1'b0);
            default: ;
        endcase
    endtask

    task automatic test_random(int gap, int stall, int count);
        int first;
        first     = sent_count;
        gap_pct   = gap;
        stall_pct = stall;
        while (sent_count - first < count) random_token();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_symbols();
        test_strings();
        test_numbers();
        test_words();
        test_comments();
        test_end_of_input();
        test_odd_bytes();
        test_long_line();
        test_backpressure();
        test_random(0, 0, 170);
        test_random(58, 0, 170);
        test_random(0, 58, 170);
        test_random(31, 31, 170);

        i_in_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_queue.sv
rtl/source_text_tokenizer_top.sv
tb/testbench.sv
